/* rtl/stli_pkg.sv */
// ----------------------------------------------------------------------------
// stli_pkg
// Shared types and constants for the sorted-table linear interpolator.
// ----------------------------------------------------------------------------
package stli_pkg;

	localparam int KEY_W = 16;  // Q4.12
	localparam int VAL_W = 16;  // Q2.14

	localparam int MAX_POINTS_DEF = 16;

	// 0.295 in Q2.14
	localparam logic [VAL_W-1:0] DEFAULT_VALUE_RESET = 16'd4833;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key_value;
		logic [VAL_W-1:0] point_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] interp_result;
		logic             status;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_Q_CHK0,
		ST_Q_CHKN,
		ST_BS_RD,
		ST_BS_CMP,
		ST_F1,
		ST_F2,
		ST_DIV,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage

/* rtl/sorted_table_linear_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_unit
// Sorted breakpoint table with clear, ordered insert and interpolating lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) takes one command beat: clear,
//   insert (key, value) or query key. req_stall is high while a command is
//   being worked on; one command is in flight at a time.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one beat per
//   command from an output register. A new command is taken while a
//   finished response still waits; a held response only delays the next
//   command's completion.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the empty-table
//   default value; it is always ready and should be used while idle.
// Sequencing: clear, nop, refused insert and empty-table query go straight
//   to the response; insert moves each larger entry up one slot until a lower
//   or equal key stops the shift; a query clamped to the first or last entry
//   ends there, else a binary search takes at most ceil(log2(n+1)) probes,
//   one read at a time on the single read port of the table memory, then
//   the restoring divider yields one quotient bit per cycle.
// Reset clears the entry count and loads the default value 0.295 (Q2.14);
//   table contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_unit #(
	parameter int MAX_POINTS = stli_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  stli_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output stli_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stli_pkg::VAL_W-1:0]    cfg_data
);
	import stli_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

	// table memories
	logic [KEY_W-1:0] key_mem [MAX_POINTS];
	logic [VAL_W-1:0] val_mem [MAX_POINTS];

	state_t state_q, state_d;

	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d, mid;
	logic [KEY_W-1:0] key_q, key_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [KEY_W-1:0] k1_q, k1_d;
	logic [VAL_W-1:0] v1_q, v1_d;
	logic [KEY_W-1:0] den_q, den_d;
	logic [KEY_W-1:0] rem_q, rem_d;
	logic [VAL_W-1:0] dq_q, dq_d;
	logic             neg_q, neg_d;
	logic [3:0]       cnt_q, cnt_d;
	logic [VAL_W-1:0] res_q, res_d;
	logic             status_q, status_d;
	logic [VAL_W-1:0] default_q;

	logic [AW-1:0]    rd_addr;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wkey;
	logic [VAL_W-1:0] mem_wval;

	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             rsp_load;

	logic [VAL_W-1:0]   dv_mag;
	logic [KEY_W-1:0]   dk;
	logic [2*VAL_W-1:0] prod;
	logic [KEY_W:0]     trial, diff;
	logic               ge;

	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// interpolation operands, taken when the upper point arrives
	assign dk     = key_q - k1_q;
	assign dv_mag = (rd_val_q < v1_q) ? (v1_q - rd_val_q) : (rd_val_q - v1_q);
	assign prod   = (2*VAL_W)'(dk) * (2*VAL_W)'(dv_mag);

	// one restoring divide step
	assign trial = {rem_q, dq_q[VAL_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		key_d     = key_q;
		val_d     = val_q;
		k1_d      = k1_q;
		v1_d      = v1_q;
		den_d     = den_q;
		rem_d     = rem_q;
		dq_d      = dq_q;
		neg_d     = neg_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		status_d  = status_q;
		rd_addr   = '0;
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wkey  = key_q;
		mem_wval  = val_q;
		rsp_load  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					key_d    = req.key_value;
					val_d    = req.point_value;
					res_d    = '0;
					status_d = 1'b0;
					case (req.op)
						OP_CLEAR: begin
							count_d = '0;
							state_d = ST_DONE;
						end
						OP_INSERT: begin
							if (count_q >= MAXC) begin
								status_d = 1'b1;
								state_d  = ST_DONE;
							end else begin
								pos_d   = count_q;
								state_d = ST_INS_RD;
							end
						end
						OP_QUERY: begin
							if (count_q == '0) begin
								res_d   = default_q;
								state_d = ST_DONE;
							end else begin
								rd_addr = '0;
								state_d = ST_Q_CHK0;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					count_d = count_q + 1'b1;
					state_d = ST_DONE;
				end else begin
					rd_addr = AW'(pos_q - 1'b1);
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (rd_key_q > key_q) begin
					// move the larger entry up one slot
					mem_wkey = rd_key_q;
					mem_wval = rd_val_q;
					pos_d    = pos_q - 1'b1;
					state_d  = ST_INS_RD;
				end else begin
					count_d = count_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_Q_CHK0: begin
				if (key_q <= rd_key_q) begin
					res_d   = rd_val_q;
					state_d = ST_DONE;
				end else begin
					rd_addr = AW'(count_q - 1'b1);
					state_d = ST_Q_CHKN;
				end
			end
			ST_Q_CHKN: begin
				if (key_q >= rd_key_q) begin
					res_d   = rd_val_q;
					state_d = ST_DONE;
				end else begin
					lo_d    = '0;
					hi_d    = count_q;
					state_d = ST_BS_RD;
				end
			end
			ST_BS_RD: begin
				if (lo_q < hi_q) begin
					rd_addr = mid[AW-1:0];
					state_d = ST_BS_CMP;
				end else begin
					// lo is the first key above the query; lower point sits below it
					rd_addr = AW'(lo_q - 1'b1);
					state_d = ST_F1;
				end
			end
			ST_BS_CMP: begin
				if (rd_key_q > key_q) begin
					hi_d = mid;
				end else begin
					lo_d = mid + 1'b1;
				end
				state_d = ST_BS_RD;
			end
			ST_F1: begin
				k1_d    = rd_key_q;
				v1_d    = rd_val_q;
				rd_addr = lo_q[AW-1:0];
				state_d = ST_F2;
			end
			ST_F2: begin
				den_d   = rd_key_q - k1_q;
				neg_d   = (rd_val_q < v1_q);
				rem_d   = prod[2*VAL_W-1:VAL_W];
				dq_d    = prod[VAL_W-1:0];
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				rem_d = ge ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
				dq_d  = {dq_q[VAL_W-2:0], ge};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 4'hf) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				res_d   = neg_q ? (v1_q - dq_q) : (v1_q + dq_q);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			default_q   <= DEFAULT_VALUE_RESET;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				default_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		key_q    <= key_d;
		val_q    <= val_d;
		k1_q     <= k1_d;
		v1_q     <= v1_d;
		den_q    <= den_d;
		rem_q    <= rem_d;
		dq_q     <= dq_d;
		neg_q    <= neg_d;
		cnt_q    <= cnt_d;
		res_q    <= res_d;
		status_q <= status_d;
		if (rsp_load) begin
			rsp_q.interp_result <= res_q;
			rsp_q.status        <= status_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wkey;
			val_mem[mem_waddr] <= mem_wval;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC)
		else $error("entry count above table size");

	a_bs_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BS_RD) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("search window out of range");

	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F1) |-> (lo_q != '0 && lo_q < count_q))
		else $error("bracketing index outside table");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0 && rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_valid_q && rsp_stall) |=> (state_q == ST_DONE))
		else $error("response dropped while output held");

endmodule
